// ===== sv/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg: shared definitions of the infix expression evaluator
// Widths, character codes, status codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package iee_pkg;

  // number formats
  localparam int OPERAND_BITS  = 31;
  localparam int FRACTION_BITS = 32;
  localparam int VALUE_BITS    = 64;
  localparam int CNT_BITS      = $clog2(VALUE_BITS);

  localparam logic [OPERAND_BITS-1:0] OPERAND_MAX = {OPERAND_BITS{1'b1}};
  localparam logic [VALUE_BITS-1:0]   VALUE_MAX   = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0]   VALUE_MIN   = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_MUL   = 8'h2a;
  localparam logic [7:0] CH_DIV   = 8'h2f;

  // pending product operator
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_MUL  = 2'd1;
  localparam logic [1:0] OP_DIV  = 2'd2;

  // status codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_DIVZERO  = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic digit;
    logic stop;
    logic fact_start;
    logic set_pending;
    logic term;
    logic set_sign;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_digit;
    logic is_prod_op;
    logic is_sum_op;
    logic last;
    logic fact_done;
    logic out_free;
  } stat_t;

  // division by zero wins, otherwise the first error sticks
  function automatic logic [1:0] flag_error(logic [1:0] cur, logic [1:0] code);
    logic [1:0] res;
    if (code == ERR_DIVZERO) begin
      res = ERR_DIVZERO;
    end else if (cur == ERR_OK) begin
      res = code;
    end else begin
      res = cur;
    end
    return res;
  endfunction

endpackage

// ===== sv/iee_ctrl.sv =====
// ----------------------------------------------------------------------------
// iee_ctrl: sequencing controller
// Walks each character through its operand, factor and term steps.
// ----------------------------------------------------------------------------
module iee_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  iee_pkg::stat_t stat_i,
  output iee_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHAR, ST_FACT, ST_WAIT, ST_TERM, ST_EMIT
  } state_e;

  // why a factor is being closed
  typedef enum logic [1:0] {
    CTX_PROD, CTX_SUM, CTX_LAST
  } ctx_e;

  state_e state_q, state_d;
  ctx_e   ctx_q, ctx_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    ctx_d      = ctx_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_CHAR;
        end
      end
      ST_CHAR: begin
        if (stat_i.is_prod_op) begin
          ctx_d   = CTX_PROD;
          state_d = ST_FACT;
        end else if (stat_i.is_sum_op) begin
          ctx_d   = CTX_SUM;
          state_d = ST_FACT;
        end else begin
          cmd_o.digit = stat_i.is_digit;
          cmd_o.stop  = !stat_i.is_digit;
          ctx_d       = CTX_LAST;
          state_d     = stat_i.last ? ST_FACT : ST_IDLE;
        end
      end
      ST_FACT: begin
        cmd_o.fact_start = 1'b1;
        state_d          = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat_i.fact_done) begin
          if (ctx_q == CTX_PROD) begin
            cmd_o.set_pending = 1'b1;
            ctx_d             = CTX_LAST;
            state_d           = stat_i.last ? ST_FACT : ST_IDLE;
          end else begin
            state_d = ST_TERM;
          end
        end
      end
      ST_TERM: begin
        cmd_o.term = 1'b1;
        if (ctx_q == CTX_SUM) begin
          cmd_o.set_sign = 1'b1;
          ctx_d          = CTX_LAST;
          state_d        = stat_i.last ? ST_FACT : ST_IDLE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ctx_q   <= CTX_LAST;
    end else begin
      state_q <= state_d;
      ctx_q   <= ctx_d;
    end
  end

endmodule

// ===== sv/iee_datapath.sv =====
// ----------------------------------------------------------------------------
// iee_datapath: expression state and arithmetic
// Operand accumulator, serial multiplier and divider, saturating sum and
// the output register.
// ----------------------------------------------------------------------------
module iee_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  iee_pkg::cmd_t                     cmd_i,
  output iee_pkg::stat_t                    stat_o,
  input  logic [7:0]                        symbol_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [iee_pkg::VALUE_BITS-1:0]    value_o,
  output logic [1:0]                        status_o
);

  localparam int OB = iee_pkg::OPERAND_BITS;
  localparam int VB = iee_pkg::VALUE_BITS;

  logic [7:0]                    sym_q, sym_d;
  logic                          last_q, last_d;
  logic [OB-1:0]                 acc_q, acc_d;
  logic                          stopped_q, stopped_d;
  logic [VB-1:0]                 term_q, term_d;
  logic [1:0]                    pend_q, pend_d;
  logic                          neg_q, neg_d;
  logic [VB-1:0]                 sum_q, sum_d;
  logic [1:0]                    err_q, err_d;
  logic                          run_mul_q, run_mul_d;
  logic                          run_div_q, run_div_d;
  logic [iee_pkg::CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [VB-1:0]                 prod_q, prod_d;
  logic                          movf_q, movf_d;
  logic [OB-1:0]                 rem_q, rem_d;
  logic                          ovalid_q, ovalid_d;
  logic [VB-1:0]                 oval_q, oval_d;
  logic [1:0]                    ostat_q, ostat_d;

  logic [OB+3:0] dig_next;
  logic [VB:0]   mul_next;
  logic          mul_ovf;
  logic [OB:0]   div_r;
  logic [OB:0]   div_diff;
  logic          div_ge;
  logic [VB:0]   sum_next;

  // arithmetic for one step
  always_comb begin
    dig_next = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + (OB+4)'(sym_q[3:0]);
    mul_next = {prod_q, 1'b0} + (acc_q[OB-1] ? {1'b0, term_q} : '0);
    mul_ovf  = movf_q | (mul_next[VB:VB-1] != 2'b00);
    div_r    = {rem_q, term_q[VB-1]};
    div_diff = div_r - {1'b0, acc_q};
    div_ge   = div_r >= {1'b0, acc_q};
    if (neg_q) begin
      sum_next = {sum_q[VB-1], sum_q} - {1'b0, term_q};
    end else begin
      sum_next = {sum_q[VB-1], sum_q} + {1'b0, term_q};
    end
  end

  // next state of the expression registers
  always_comb begin
    sym_d     = sym_q;
    last_d    = last_q;
    acc_d     = acc_q;
    stopped_d = stopped_q;
    term_d    = term_q;
    pend_d    = pend_q;
    neg_d     = neg_q;
    sum_d     = sum_q;
    err_d     = err_q;
    run_mul_d = run_mul_q;
    run_div_d = run_div_q;
    cnt_d     = cnt_q;
    prod_d    = prod_q;
    movf_d    = movf_q;
    rem_d     = rem_q;
    ovalid_d  = ovalid_q & !out_ready_i;
    oval_d    = oval_q;
    ostat_d   = ostat_q;

    if (cmd_i.latch) begin
      sym_d  = symbol_i;
      last_d = last_i;
    end

    // operand digit
    if (cmd_i.digit && !stopped_q) begin
      if (dig_next > (OB+4)'(iee_pkg::OPERAND_MAX)) begin
        acc_d = iee_pkg::OPERAND_MAX;
        err_d = iee_pkg::flag_error(err_q, iee_pkg::ERR_OVERFLOW);
      end else begin
        acc_d = dig_next[OB-1:0];
      end
    end

    if (cmd_i.stop) begin
      stopped_d = 1'b1;
    end

    // close the factor
    if (cmd_i.fact_start) begin
      stopped_d = 1'b0;
      case (pend_q)
        iee_pkg::OP_MUL: begin
          if (acc_q == '0) begin
            term_d = '0;
          end else begin
            run_mul_d = 1'b1;
            prod_d    = '0;
            movf_d    = 1'b0;
            cnt_d     = iee_pkg::CNT_BITS'(OB - 1);
          end
        end
        iee_pkg::OP_DIV: begin
          if (acc_q == '0) begin
            term_d = '0;
            err_d  = iee_pkg::flag_error(err_q, iee_pkg::ERR_DIVZERO);
          end else begin
            run_div_d = 1'b1;
            rem_d     = '0;
            cnt_d     = iee_pkg::CNT_BITS'(VB - 1);
          end
        end
        default: begin
          term_d = VB'(acc_q) << iee_pkg::FRACTION_BITS;
          acc_d  = '0;
        end
      endcase
    end

    // multiplier, one operand bit per cycle from the top
    if (run_mul_q) begin
      prod_d = mul_next[VB-1:0];
      movf_d = mul_ovf;
      acc_d  = acc_q << 1;
      cnt_d  = cnt_q - iee_pkg::CNT_BITS'(1);
      if (cnt_q == '0) begin
        run_mul_d = 1'b0;
        if (mul_ovf) begin
          term_d = iee_pkg::VALUE_MAX;
          err_d  = iee_pkg::flag_error(err_q, iee_pkg::ERR_OVERFLOW);
        end else begin
          term_d = mul_next[VB-1:0];
        end
      end
    end

    // restoring divider, one quotient bit per cycle
    if (run_div_q) begin
      rem_d  = div_ge ? div_diff[OB-1:0] : div_r[OB-1:0];
      term_d = {term_q[VB-2:0], div_ge};
      cnt_d  = cnt_q - iee_pkg::CNT_BITS'(1);
      if (cnt_q == '0) begin
        run_div_d = 1'b0;
        acc_d     = '0;
      end
    end

    if (cmd_i.set_pending) begin
      pend_d = (sym_q == iee_pkg::CH_MUL) ? iee_pkg::OP_MUL : iee_pkg::OP_DIV;
    end

    // fold the term into the saturating sum
    if (cmd_i.term) begin
      if (sum_next[VB] != sum_next[VB-1]) begin
        sum_d = sum_next[VB] ? iee_pkg::VALUE_MIN : iee_pkg::VALUE_MAX;
        err_d = iee_pkg::flag_error(err_q, iee_pkg::ERR_OVERFLOW);
      end else begin
        sum_d = sum_next[VB-1:0];
      end
      term_d = '0;
      pend_d = iee_pkg::OP_NONE;
      if (cmd_i.set_sign) begin
        neg_d = (sym_q == iee_pkg::CH_MINUS);
      end
    end

    // result transfer and fresh expression
    if (cmd_i.emit) begin
      ovalid_d  = 1'b1;
      oval_d    = (err_q == iee_pkg::ERR_DIVZERO) ? '0 : sum_q;
      ostat_d   = err_q;
      acc_d     = '0;
      stopped_d = 1'b0;
      term_d    = '0;
      pend_d    = iee_pkg::OP_NONE;
      neg_d     = 1'b0;
      sum_d     = '0;
      err_d     = iee_pkg::ERR_OK;
    end
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      stopped_q <= 1'b0;
      term_q    <= '0;
      pend_q    <= iee_pkg::OP_NONE;
      neg_q     <= 1'b0;
      sum_q     <= '0;
      err_q     <= iee_pkg::ERR_OK;
      run_mul_q <= 1'b0;
      run_div_q <= 1'b0;
      cnt_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      stopped_q <= stopped_d;
      term_q    <= term_d;
      pend_q    <= pend_d;
      neg_q     <= neg_d;
      sum_q     <= sum_d;
      err_q     <= err_d;
      run_mul_q <= run_mul_d;
      run_div_q <= run_div_d;
      cnt_q     <= cnt_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sym_q   <= sym_d;
    last_q  <= last_d;
    prod_q  <= prod_d;
    movf_q  <= movf_d;
    rem_q   <= rem_d;
    oval_q  <= oval_d;
    ostat_q <= ostat_d;
  end

  // status to the controller
  always_comb begin
    stat_o.is_digit   = (sym_q >= iee_pkg::CH_ZERO) && (sym_q <= iee_pkg::CH_NINE);
    stat_o.is_prod_op = (sym_q == iee_pkg::CH_MUL) || (sym_q == iee_pkg::CH_DIV);
    stat_o.is_sum_op  = (sym_q == iee_pkg::CH_PLUS) || (sym_q == iee_pkg::CH_MINUS);
    stat_o.last       = last_q;
    stat_o.fact_done  = !run_mul_q && !run_div_q;
    stat_o.out_free   = !ovalid_q || out_ready_i;
  end

  assign out_valid_o = ovalid_q;
  assign value_o     = oval_q;
  assign status_o    = ostat_q;

endmodule

// ===== sv/infix_expression_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top: streaming infix expression evaluator
// Evaluates + - * / over unsigned decimal operands, result in signed Q32.32.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                      tuser / tlast
//  s_axis    in         [7:0] symbol               tlast = last character
//  m_axis    out        [63:0] value               tuser[1:0] = status
//
//  one character at a time: a digit or other character is latched and then
//  classified, * or / also close a factor, + or - close one and update the sum;
//  closing a factor after a * runs the serial multiplier, after a / the
//  restoring divider; the last character adds one factor close, the sum
//  update and the result slot.
//  reset clears the expression state and drops m_axis_tvalid.
//  a held result stalls the last character of the next expression only.
module infix_expression_evaluator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] value
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  iee_pkg::cmd_t  cmd;
  iee_pkg::stat_t stat;

  // sequencing
  iee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // arithmetic and state
  iee_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .symbol_i    (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .value_o     (m_axis_tdata),
    .status_o    (m_axis_tuser)
  );

endmodule

// ===== sv/iee_checker.sv =====
// ----------------------------------------------------------------------------
// iee_checker: port level checks of the expression evaluator
// Watches the stream ports and reports violations.
// ----------------------------------------------------------------------------
module iee_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a result waits until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transfer");

  // status code three is never produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("invalid status code");

  // division by zero gives a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == 2'd1 |-> m_axis_tdata == 64'd0)
    else $error("nonzero value with division by zero");

  // a character is worked on before the next one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

endmodule

bind infix_expression_evaluator_top iee_checker u_iee_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/infix_expression_evaluator_top_tb.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator_top_tb: self-checking bench of the evaluator
// Streams random and directed expressions, predicts each value and status
// in the bench and compares every result transfer in order.
// ----------------------------------------------------------------------------

// expected results and the expression state that produces them
class expr_scoreboard;
  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } result_t;

  result_t     pending_q[$];
  logic [31:0] acc;
  bit          stopped;
  logic [63:0] term;
  logic [1:0]  prod_op;
  bit          neg;
  logic signed [63:0] sum;
  logic [1:0]  err;
  int          mismatches;
  int          results_seen;

  function new();
    clear_expr();
    mismatches = 0;
    results_seen = 0;
  endfunction

  function void clear_expr();
    acc = 0;
    stopped = 0;
    term = 0;
    prod_op = iee_pkg::OP_NONE;
    neg = 0;
    sum = 0;
    err = iee_pkg::ERR_OK;
  endfunction

  function void raise_err(logic [1:0] code);
    if (code == iee_pkg::ERR_DIVZERO) err = iee_pkg::ERR_DIVZERO;
    else if (err == iee_pkg::ERR_OK) err = code;
  endfunction

  // fold the operand into the term
  function void fold_factor();
    logic [63:0] v;
    logic [63:0] lim;
    v = {32'd0, acc};
    lim = iee_pkg::VALUE_MAX;
    if (prod_op == iee_pkg::OP_MUL) begin
      if (v != 0 && term > lim / v) begin
        term = lim;
        raise_err(iee_pkg::ERR_OVERFLOW);
      end else begin
        term = term * v;
      end
    end else if (prod_op == iee_pkg::OP_DIV) begin
      if (v == 0) begin
        term = 0;
        raise_err(iee_pkg::ERR_DIVZERO);
      end else begin
        term = term / v;
      end
    end else begin
      term = v << iee_pkg::FRACTION_BITS;
    end
    acc = 0;
    stopped = 0;
  endfunction

  // fold the term into the sum with saturation
  function void fold_term();
    logic signed [63:0] t;
    logic signed [63:0] smin;
    logic signed [63:0] smax;
    fold_factor();
    t = term;
    smin = iee_pkg::VALUE_MIN;
    smax = iee_pkg::VALUE_MAX;
    if (neg) begin
      if (sum < smin + t) begin
        sum = smin;
        raise_err(iee_pkg::ERR_OVERFLOW);
      end else begin
        sum = sum - t;
      end
    end else begin
      if (sum > smax - t) begin
        sum = smax;
        raise_err(iee_pkg::ERR_OVERFLOW);
      end else begin
        sum = sum + t;
      end
    end
    term = 0;
    prod_op = iee_pkg::OP_NONE;
  endfunction

  // note an accepted character
  function void note_symbol(logic [7:0] c, bit is_last);
    logic [31:0] d;
    result_t r;
    if (c >= iee_pkg::CH_ZERO && c <= iee_pkg::CH_NINE) begin
      if (!stopped) begin
        d = {24'd0, c - iee_pkg::CH_ZERO};
        if (acc > ({1'b0, iee_pkg::OPERAND_MAX} - d) / 10) begin
          acc = {1'b0, iee_pkg::OPERAND_MAX};
          raise_err(iee_pkg::ERR_OVERFLOW);
        end else begin
          acc = acc * 10 + d;
        end
      end
    end else if (c == iee_pkg::CH_MUL || c == iee_pkg::CH_DIV) begin
      fold_factor();
      prod_op = (c == iee_pkg::CH_MUL) ? iee_pkg::OP_MUL : iee_pkg::OP_DIV;
    end else if (c == iee_pkg::CH_PLUS || c == iee_pkg::CH_MINUS) begin
      fold_term();
      neg = (c == iee_pkg::CH_MINUS);
    end else begin
      stopped = 1;
    end
    if (is_last) begin
      fold_term();
      r.value = (err == iee_pkg::ERR_DIVZERO) ? 64'd0 : sum;
      r.status = err;
      pending_q.push_back(r);
      clear_expr();
    end
  endfunction

  // check one result transfer
  function void check_result(logic [63:0] value, logic [1:0] status);
    result_t r;
    results_seen++;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result value=%h status=%0d", value, status);
      return;
    end
    r = pending_q.pop_front();
    if (r.value !== value || r.status !== status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                 r.value, r.status, value, status);
    end
  endfunction
endclass

module infix_expression_evaluator_top_tb;
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  expr_scoreboard sb;
  int  sent;
  int  cycles;
  bit  quiet;

  infix_expression_evaluator_top DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stall bursts, check each transfer
  initial begin
    int burst;
    m_axis_tready = 1'b0;
    burst = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (burst > 0) begin
        burst--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 4) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one character transfer, with an optional idle burst first
  task automatic send_symbol(logic [7:0] c, bit is_last);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_symbol(c, is_last);
    sent++;
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_symbol(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'(iee_pkg::CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_op();
    logic [7:0] ops[4];
    ops = '{iee_pkg::CH_PLUS, iee_pkg::CH_MINUS, iee_pkg::CH_MUL, iee_pkg::CH_DIV};
    return ops[$urandom_range(0, 3)];
  endfunction

  // a mostly well formed expression with random operands, short numbers mostly
  task automatic send_expression();
    int nterms;
    int ndig;
    nterms = $urandom_range(1, 5);
    for (int t = 0; t < nterms; t++) begin
      ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
      for (int d = 0; d < ndig; d++) begin
        if ($urandom_range(0, 40) == 0) send_symbol(8'($urandom_range(0, 255)), 1'b0);
        else send_symbol(rand_digit(), 1'b0);
      end
      if (t < nterms - 1) send_symbol(rand_op(), 1'b0);
    end
    send_symbol(rand_digit(), 1'b1);
  endtask

  // stop sending and wait for every expected result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    sent = 0;
    quiet = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: precedence, empty operands, stray characters, saturation
    send_string("1+2*3");
    send_string("-7/0");
    send_string("99999999999");
    send_string("8/3-1*");
    send_string("12a34*");
    send_symbol(8'hff, 1'b1);
    send_string("2147483647*2147483647*9");
    send_string("0-2147483647*2147483647*3");

    // hold off until every result has come
    drain();
    repeat (100) @(posedge clk_i);

    // random: mostly well formed, some noise
    while (sent < 1700) begin
      if (sent > 1400) quiet = 1;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) send_symbol(8'($urandom_range(0, 255)), 1'b0);
        send_symbol(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_expression();
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("sent %0d characters, checked %0d results, %0d mismatches",
             sent, sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
